### rtl/weighted_server_select_assert.svh
// Assertion macros for the checker module of this block.
`ifndef WEIGHTED_SERVER_SELECT_ASSERT_SVH
`define WEIGHTED_SERVER_SELECT_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle, outside reset.
`define WSS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Check that a condition implies a consequence in the next cycle, outside reset.
`define WSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

// Check a next-cycle implication that also holds across reset.
`define WSS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication across reset");

`endif

### rtl/wss_pkg.sv
package wss_pkg;

  // Default sizes of the slot table
  localparam int SLOTS_DEF       = 16;
  localparam int WEIGHT_BITS_DEF = 16;

  // Fixed field widths of the stream items
  localparam int PICK_W      = 64;
  localparam int SLOT_FW     = 4;
  localparam int WEIGHT_FW   = 16;
  localparam int S_TDATA_W   = 88;
  localparam int M_TDATA_W   = 8;

  // Bit positions inside s_tdata
  localparam int SLOT_LSB    = 0;
  localparam int WEIGHT_LSB  = 4;
  localparam int MEMBER_BIT  = 20;
  localparam int PICK_LSB    = 21;

  // Configuration port
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;
  localparam int REG_IDX_BIT = 2;
  localparam logic REG_SELECT_MODE = 1'b0;

  // Item kinds carried in s_tuser
  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SELECT = 1'b1;

  // Selection modes
  localparam logic MODE_RR       = 1'b0;
  localparam logic MODE_WEIGHTED = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_PREP,
    ST_MOD,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Control into and status out of the serial modulo unit
  typedef struct packed {
    logic start;
  } mod_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mod_sts_t;

endpackage

### rtl/wss_slot_table.sv
module wss_slot_table #(
  parameter int SLOTS       = wss_pkg::SLOTS_DEF,
  parameter int WEIGHT_BITS = wss_pkg::WEIGHT_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  logic [$clog2(SLOTS)-1:0] wr_addr,
  input  logic [WEIGHT_BITS-1:0]   wr_weight,
  input  logic                     wr_member,
  input  logic [$clog2(SLOTS)-1:0] rd_addr,
  output logic [WEIGHT_BITS-1:0]   rd_weight,
  output logic                     rd_member
);
  import wss_pkg::*;

  logic [WEIGHT_BITS-1:0] weight_mem [SLOTS];
  logic [SLOTS-1:0]       member;

  // Write one weight; the read weight is registered
  always_ff @(posedge clk) begin
    if (wr_en) begin
      weight_mem[wr_addr] <= wr_weight;
    end
    rd_weight <= weight_mem[rd_addr];
  end

  // Member flags clear at reset, so the pool starts empty
  always_ff @(posedge clk) begin
    if (rst) begin
      member    <= '0;
      rd_member <= 1'b0;
    end else begin
      if (wr_en) begin
        member[wr_addr] <= wr_member;
      end
      rd_member <= member[rd_addr];
    end
  end

endmodule

### rtl/wss_serial_mod.sv
module wss_serial_mod #(
  parameter int PICK_W = wss_pkg::PICK_W,
  parameter int DIV_W  = wss_pkg::WEIGHT_BITS_DEF + 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  wss_pkg::mod_ctl_t    ctl,
  input  logic [PICK_W-1:0]    dividend,
  input  logic [DIV_W-1:0]     divisor,
  output wss_pkg::mod_sts_t    sts,
  output logic [DIV_W-1:0]     remainder
);
  import wss_pkg::*;

  localparam int CNT_W = $clog2(PICK_W + 1);

  logic [CNT_W-1:0]  cnt;
  logic [PICK_W-1:0] quo;
  logic [DIV_W-1:0]  rem;
  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    diff;
  logic              fits;
  logic [DIV_W-1:0]  rem_next;

  // One restoring step: bring in the next dividend bit, subtract if it fits
  always_comb begin
    trial    = {rem, quo[PICK_W-1]};
    diff     = trial - {1'b0, divisor};
    fits     = trial >= {1'b0, divisor};
    rem_next = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
  end

  // Step counter and status; done pulses the cycle after the last step
  always_ff @(posedge clk) begin
    if (rst) begin
      sts <= '0;
      cnt <= '0;
    end else begin
      sts.done <= !ctl.start && sts.busy && cnt == CNT_W'(1);
      if (ctl.start) begin
        sts.busy <= 1'b1;
        cnt      <= CNT_W'(PICK_W);
      end else if (sts.busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          sts.busy <= 1'b0;
        end
      end
    end
  end

  // Shift the dividend out MSB first, update the partial remainder
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      quo <= dividend;
      rem <= '0;
    end else if (sts.busy) begin
      quo <= quo << 1;
      rem <= rem_next;
    end
  end

  assign remainder = rem;

endmodule

### rtl/weighted_server_select.sv
// Select item: a sum pass over the table, a check state, serial modulo (one
// pick bit per cycle, then a done pulse), a scan pass that stops at the first
// hit, and an output state that waits while the result register is stalled.
// Empty pool or zero total skips modulo and scan. The next item is taken in
// the cycle after the result loads. Write item: taken only while idle.
// Synchronous active-high reset empties the pool and sets weighted mode.
module weighted_server_select #(
  parameter int SLOTS       = wss_pkg::SLOTS_DEF,
  parameter int WEIGHT_BITS = wss_pkg::WEIGHT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // s_tdata: slot[3:0], weight[19:4], member[20], pick_value[84:21], zeros
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [wss_pkg::S_TDATA_W-1:0] s_tdata,
  // s_tuser: action[0]
  input  logic [0:0]                    s_tuser,
  // m_tdata: chosen_slot[3:0], zeros
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [wss_pkg::M_TDATA_W-1:0] m_tdata,
  // m_tuser: found[0]
  output logic [0:0]                    m_tuser,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wss_pkg::APB_AW-1:0]    paddr,
  input  logic [wss_pkg::APB_DW-1:0]    pwdata,
  output logic [wss_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);
  import wss_pkg::*;

  localparam int SIDX_W = $clog2(SLOTS);
  localparam int CNT_W  = SIDX_W + 1;
  localparam int TOT_W  = WEIGHT_BITS + SIDX_W;

  state_t state, state_next;

  logic                   select_mode;
  logic [CNT_W-1:0]       cnt;
  logic                   vld_d;
  logic [SIDX_W-1:0]      idx_d;
  logic [TOT_W-1:0]       total;
  logic [CNT_W-1:0]       nmem;
  logic [TOT_W-1:0]       run;
  logic [TOT_W-1:0]       run_next;
  logic [TOT_W-1:0]       divisor;
  logic [TOT_W-1:0]       remainder;
  logic [PICK_W-1:0]      pick;
  logic                   res_found;
  logic [SIDX_W-1:0]      res_slot;
  logic                   out_found;
  logic [SLOT_FW-1:0]     out_slot;
  logic [SIDX_W+SLOT_FW-1:0] slot_ext;
  logic [SIDX_W+SLOT_FW-1:0] addr_ext;
  logic [WEIGHT_BITS+WEIGHT_FW-1:0] weight_ext;

  logic                   tbl_wr;
  logic [SIDX_W-1:0]      wr_addr;
  logic [WEIGHT_BITS-1:0] wr_weight;
  logic [WEIGHT_BITS-1:0] rd_weight;
  logic                   rd_member;
  logic                   accept_sel;
  logic                   scan_end;
  logic                   hit;
  logic                   load_out;
  logic                   cfg_wr;
  mod_ctl_t               mod_ctl;
  mod_sts_t               mod_sts;

  // Input field extraction, sized to the table
  assign addr_ext   = {{SIDX_W{1'b0}}, s_tdata[SLOT_LSB +: SLOT_FW]};
  assign wr_addr    = addr_ext[SIDX_W-1:0];
  assign weight_ext = {{WEIGHT_BITS{1'b0}}, s_tdata[WEIGHT_LSB +: WEIGHT_FW]};
  assign wr_weight  = weight_ext[WEIGHT_BITS-1:0];

  assign divisor  = (select_mode == MODE_WEIGHTED) ? total : TOT_W'(nmem);
  assign run_next = run + ((select_mode == MODE_WEIGHTED) ? TOT_W'(rd_weight)
                                                          : TOT_W'(1));
  assign hit      = vld_d && rd_member && (run_next > remainder);
  assign scan_end = cnt == CNT_W'(SLOTS);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (s_tvalid && s_tuser[0] == ACT_SELECT) state_next = ST_SUM;
      ST_SUM:  if (scan_end) state_next = ST_PREP;
      ST_PREP: state_next = (divisor == '0) ? ST_DONE : ST_MOD;
      ST_MOD:  if (mod_sts.done) state_next = ST_SCAN;
      ST_SCAN: if (hit || scan_end) state_next = ST_DONE;
      ST_DONE: if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    s_tready      = 1'b0;
    tbl_wr        = 1'b0;
    accept_sel    = 1'b0;
    mod_ctl.start = 1'b0;
    load_out      = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready   = 1'b1;
        tbl_wr     = s_tvalid && s_tuser[0] == ACT_WRITE &&
                     32'(s_tdata[SLOT_LSB +: SLOT_FW]) < SLOTS;
        accept_sel = s_tvalid && s_tuser[0] == ACT_SELECT;
      end
      ST_PREP: mod_ctl.start = divisor != '0;
      ST_DONE: load_out = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Scan counter and delayed read tag, shared by sum and select passes
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      vld_d <= 1'b0;
    end else begin
      vld_d <= (state == ST_SUM || state == ST_SCAN) && cnt < CNT_W'(SLOTS);
      if (accept_sel || (state == ST_MOD && mod_sts.done)) begin
        cnt <= '0;
      end else if ((state == ST_SUM || state == ST_SCAN) && !scan_end) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  // Accumulate totals, scan running weight, hold the result
  always_ff @(posedge clk) begin
    idx_d <= cnt[SIDX_W-1:0];
    if (accept_sel) begin
      total <= '0;
      nmem  <= '0;
      pick  <= s_tdata[PICK_LSB +: PICK_W];
    end
    if (state == ST_SUM && vld_d && rd_member) begin
      total <= total + TOT_W'(rd_weight);
      nmem  <= nmem + 1'b1;
    end
    if (state == ST_MOD && mod_sts.done) begin
      run <= '0;
    end
    if (state == ST_PREP && divisor == '0) begin
      res_found <= 1'b0;
      res_slot  <= '0;
    end
    if (state == ST_SCAN) begin
      if (vld_d && rd_member) begin
        run <= run_next;
      end
      if (hit) begin
        res_found <= 1'b1;
        res_slot  <= idx_d;
      end else if (scan_end) begin
        res_found <= 1'b0;
        res_slot  <= '0;
      end
    end
  end

  // Output register
  assign slot_ext = {{SLOT_FW{1'b0}}, res_slot};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_found <= res_found;
      out_slot  <= slot_ext[SLOT_FW-1:0];
    end
  end

  assign m_tdata = {{(M_TDATA_W - SLOT_FW){1'b0}}, out_slot};
  assign m_tuser = out_found;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      select_mode <= MODE_WEIGHTED;
    end else if (cfg_wr && paddr[REG_IDX_BIT] == REG_SELECT_MODE) begin
      select_mode <= pwdata[0];
    end
  end

  assign prdata = (paddr[REG_IDX_BIT] == REG_SELECT_MODE) ?
                  {{(APB_DW - 1){1'b0}}, select_mode} : '0;

  wss_slot_table #(
    .SLOTS       (SLOTS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_table (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (tbl_wr),
    .wr_addr   (wr_addr),
    .wr_weight (wr_weight),
    .wr_member (s_tdata[MEMBER_BIT]),
    .rd_addr   (cnt[SIDX_W-1:0]),
    .rd_weight (rd_weight),
    .rd_member (rd_member)
  );

  wss_serial_mod #(
    .PICK_W (PICK_W),
    .DIV_W  (TOT_W)
  ) u_mod (
    .clk       (clk),
    .rst       (rst),
    .ctl       (mod_ctl),
    .dividend  (pick),
    .divisor   (divisor),
    .sts       (mod_sts),
    .remainder (remainder)
  );

endmodule

### rtl/wss_checker.sv
`include "weighted_server_select_assert.svh"

module wss_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [wss_pkg::M_TDATA_W-1:0] m_tdata,
  input logic [0:0]                    m_tuser,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [wss_pkg::APB_AW-1:0]    paddr,
  input logic [wss_pkg::APB_DW-1:0]    pwdata,
  input logic [wss_pkg::APB_DW-1:0]    prdata,
  input logic                          pready
);
  import wss_pkg::*;

  // A stalled result keeps its valid and its payload
  `WSS_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

  // An empty result reports slot zero
  `WSS_ASSERT_NOW(a_miss_zero, clk, rst, m_tvalid && !m_tuser[0], m_tdata == '0)

  // Reset drops any pending result
  `WSS_ASSERT_NEXT_ALWAYS(a_rst_clear, clk, rst, !m_tvalid)

  // A mode write reads back on the next cycle
  `WSS_ASSERT_NEXT(a_mode_readback, clk, rst, psel && penable && pwrite && pready && !paddr[REG_IDX_BIT], paddr[REG_IDX_BIT] || prdata[0] == $past(pwdata[0]))

endmodule

bind weighted_server_select wss_checker u_wss_checker (.*);

### sim/weighted_server_select_checker.sv
module weighted_server_select_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  // s_tdata: slot[3:0], weight[19:4], member[20], pick_value[84:21], zeros
  input  logic [wss_pkg::S_TDATA_W-1:0] s_tdata,
  // s_tuser: action[0]
  input  logic [0:0]                    s_tuser,
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  // m_tdata: chosen_slot[3:0], zeros
  input  logic [wss_pkg::M_TDATA_W-1:0] m_tdata,
  // m_tuser: found[0]
  input  logic [0:0]                    m_tuser,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wss_pkg::APB_AW-1:0]    paddr,
  input  logic [wss_pkg::APB_DW-1:0]    pwdata,
  input  logic                          pready,
  output int                            mismatches,
  output int                            open_picks
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOTS = wss_pkg::SLOTS_DEF;

  typedef struct packed {
    logic                        found;
    logic [wss_pkg::SLOT_FW-1:0] slot;
  } pick_result_t;

  // Shadow of the server table and the mode register
  logic [wss_pkg::WEIGHT_FW-1:0] weight_tbl [NSLOTS];
  logic [NSLOTS-1:0]             member_mask;
  logic                          sel_mode;
  pick_result_t                  pending_picks[$];
  int                            err_count = 0;

  initial begin
    mismatches = 0;
    open_picks = 0;
  end

  // Work out which server a select item picks from the current table
  function automatic pick_result_t choose_server(input logic [wss_pkg::PICK_W-1:0] pick);
    logic [63:0]  total;
    logic [63:0]  count;
    logic [63:0]  target;
    logic [63:0]  run;
    logic [63:0]  seen;
    pick_result_t res;
    res   = '0;
    total = '0;
    count = '0;
    run   = '0;
    seen  = '0;
    for (int i = 0; i < NSLOTS; i++) begin
      if (member_mask[i]) begin
        count = count + 1;
        total = total + weight_tbl[i];
      end
    end
    if (sel_mode == wss_pkg::MODE_RR) begin
      if (count != 0) begin
        target = pick % count;
        for (int i = 0; i < NSLOTS; i++) begin
          if (member_mask[i]) begin
            if (seen == target && !res.found) begin
              res.found = 1'b1;
              res.slot  = 4'(i);
            end
            seen = seen + 1;
          end
        end
      end
    end else if (total != 0) begin
      // first member whose running weight passes the remainder
      target = pick % total;
      for (int i = 0; i < NSLOTS; i++) begin
        if (member_mask[i]) begin
          run = run + weight_tbl[i];
          if (run > target && !res.found) begin
            res.found = 1'b1;
            res.slot  = 4'(i);
          end
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    pick_result_t got;
    pick_result_t want;
    if (rst) begin
      for (int i = 0; i < NSLOTS; i++) weight_tbl[i] = '0;
      member_mask = '0;
      sel_mode    = wss_pkg::MODE_WEIGHTED;
      pending_picks.delete();
    end else begin
      // track mode register writes
      if (psel && penable && pwrite && pready &&
          paddr[wss_pkg::APB_AW-1:wss_pkg::REG_IDX_BIT] == wss_pkg::REG_SELECT_MODE) begin
        sel_mode = pwdata[0];
      end

      // compare each result item with the oldest prediction
      if (m_tvalid && m_tready) begin
        got.found = m_tuser[0];
        got.slot  = m_tdata[wss_pkg::SLOT_FW-1:0];
        if (pending_picks.size() == 0) begin
          $display("%0t: result with no select pending, got found=%0d chosen_slot=%0d",
                   $time, got.found, got.slot);
          err_count++;
        end else begin
          want = pending_picks.pop_front();
          if (got.found !== want.found) begin
            $display("%0t: found mismatch, expected %0d, got %0d",
                     $time, want.found, got.found);
            err_count++;
          end
          if (got.slot !== want.slot) begin
            $display("%0t: chosen_slot mismatch, expected %0d, got %0d",
                     $time, want.slot, got.slot);
            err_count++;
          end
        end
      end

      // apply table writes, predict selects
      if (s_tvalid && s_tready) begin
        if (s_tuser[0] == wss_pkg::ACT_SELECT) begin
          pending_picks.insert(pending_picks.size(),
                               choose_server(s_tdata[wss_pkg::PICK_LSB +: wss_pkg::PICK_W]));
        end else begin
          weight_tbl[s_tdata[wss_pkg::SLOT_LSB +: wss_pkg::SLOT_FW]] =
            s_tdata[wss_pkg::WEIGHT_LSB +: wss_pkg::WEIGHT_FW];
          member_mask[s_tdata[wss_pkg::SLOT_LSB +: wss_pkg::SLOT_FW]] =
            s_tdata[wss_pkg::MEMBER_BIT];
        end
      end
    end
    mismatches <= err_count;
    open_picks <= pending_picks.size();
  end

endmodule

### sim/weighted_server_select_test.sv
module weighted_server_select_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REST_CYCLES     = 120;
  localparam int QUIET_LIMIT     = 2000;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 72;

  localparam logic [wss_pkg::PICK_W-1:0] ALL_ONES = '1;
  localparam logic [wss_pkg::APB_AW-1:0] MODE_ADDR  = {wss_pkg::REG_SELECT_MODE, 2'b00};
  localparam logic [wss_pkg::APB_AW-1:0] SPARE_ADDR = {~wss_pkg::REG_SELECT_MODE, 2'b00};

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [wss_pkg::S_TDATA_W-1:0] s_tdata = '0;
  logic [0:0]                    s_tuser = '0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [wss_pkg::M_TDATA_W-1:0] m_tdata;
  logic [0:0]                    m_tuser;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [wss_pkg::APB_AW-1:0]    paddr = '0;
  logic [wss_pkg::APB_DW-1:0]    pwdata = '0;
  logic [wss_pkg::APB_DW-1:0]    prdata;
  logic                          pready;

  int mismatches;
  int open_picks;
  int send_run = 0;
  int recv_run = 0;
  int quiet_cycles = 0;

  weighted_server_select dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  weighted_server_select_checker checker_i (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .mismatches(mismatches), .open_picks(open_picks)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Draw an idle count; now and then start a run of back-to-back items
  function automatic int draw_wait(inout int run_left);
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) run_left = $urandom_range(5, 20);
    return $urandom_range(0, 11);
  endfunction

  // Offer one item, hold it until accepted
  task automatic push_item(input logic act, input logic [3:0] sl, input logic [15:0] wt,
                           input logic mem, input logic [63:0] pk);
    int gap;
    gap = draw_wait(send_run);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {3'b000, pk, mem, wt, sl};
    do @(posedge clk); while (!s_tready);
  endtask

  // Table write; pick field carries noise
  task automatic send_write(input logic [3:0] sl, input logic [15:0] wt, input logic mem);
    push_item(wss_pkg::ACT_WRITE, sl, wt, mem, {$urandom, $urandom});
  endtask

  // Select; slot, weight and member carry noise
  task automatic send_select(input logic [63:0] pk);
    push_item(wss_pkg::ACT_SELECT, 4'($urandom), 16'($urandom), 1'($urandom), pk);
  endtask

  // Stop sending, wait for every result, then let the block go quiet
  task automatic drain_and_rest();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (open_picks != 0) @(posedge clk);
    repeat (REST_CYCLES) @(posedge clk);
  endtask

  // Setup cycle, then access cycle
  task automatic cfg_write(input logic [wss_pkg::APB_AW-1:0] addr,
                           input logic [wss_pkg::APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Result side: stall before or after each result shows up
  initial begin
    int stall;
    forever begin
      stall = draw_wait(recv_run);
      if (stall > 0) begin
        m_tready <= 1'b0;
        if ($urandom_range(0, 1) == 1) begin
          do @(posedge clk); while (!m_tvalid);
        end
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // Give up when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [wss_pkg::APB_DW-1:0] mode_word;
    logic [15:0]                wt;
    logic [63:0]                pk;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Weighted mode out of reset: empty pool, zero total, extremes
    send_select(64'd0);
    send_write(4'd0, 16'd0, 1'b1);
    send_select(ALL_ONES);
    send_write(4'd15, 16'hFFFF, 1'b1);
    send_write(4'd3, 16'd1, 1'b1);
    send_select(64'd0);
    send_select(64'd1);
    send_select(ALL_ONES);
    send_write(4'd7, 16'h5555, 1'b0);
    send_select(64'd65536);
    // zero-weight member must be skipped
    send_write(4'd3, 16'd0, 1'b1);
    send_select(64'd0);
    send_select({$urandom, $urandom});

    // Round robin over the same pool
    drain_and_rest();
    cfg_write(MODE_ADDR, {31'($urandom), wss_pkg::MODE_RR});
    send_select(64'd0);
    send_select(ALL_ONES);
    send_select(64'd2);
    send_write(4'd15, 16'hFFFF, 1'b0);
    send_select(64'd5);
    send_write(4'd0, 16'd9, 1'b0);
    send_write(4'd3, 16'd0, 1'b0);
    send_select(ALL_ONES);

    // Write to the unused register index; mode must stay round robin
    drain_and_rest();
    cfg_write(SPARE_ADDR, '1);
    send_write(4'd8, 16'd4, 1'b1);
    send_select(64'd3);

    // Random phases, alternating modes
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_and_rest();
      if ($urandom_range(0, 2) == 0) cfg_write(SPARE_ADDR, $urandom);
      mode_word    = $urandom;
      mode_word[0] = (ph % 2 == 0) ? wss_pkg::MODE_WEIGHTED : wss_pkg::MODE_RR;
      cfg_write(MODE_ADDR, mode_word);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 99) < 35) begin
          case ($urandom_range(0, 3))
            0:       wt = 16'd0;
            1:       wt = 16'($urandom_range(1, 15));
            2:       wt = 16'hFFFF;
            default: wt = 16'($urandom);
          endcase
          send_write(4'($urandom), wt, $urandom_range(0, 9) < 7);
        end else begin
          case ($urandom_range(0, 3))
            0:       pk = ALL_ONES;
            1:       pk = 64'($urandom_range(0, 40));
            default: pk = {$urandom, $urandom};
          endcase
          send_select(pk);
        end
      end
    end

    drain_and_rest();
    if (mismatches == 0 && open_picks == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
